// File: rtl/slc_pkg.sv
// ---------------------------------------------------------------------------
// slc_pkg
// Shared types, constants and codes of the set-associative LRU cache model.
// ---------------------------------------------------------------------------
package slc_pkg;

   // geometry of the line store
   localparam int MAX_SET_BITS = 8;
   localparam int MAX_WAYS     = 8;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int TREE_LEAVES  = 1 << WAY_IDX_W;

   // field widths
   localparam int WORD_W       = 32;
   localparam int OP_W         = 2;
   localparam int CFG_SET_W    = 4;
   localparam int CFG_BLOCK_W  = 5;
   localparam int CFG_WAYS_W   = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;
   localparam int SPLIT_W      = 6;

   // configuration reset values
   localparam int SET_BITS_RST   = 4;
   localparam int BLOCK_BITS_RST = 4;
   localparam int WAYS_RST       = 1;

   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [SET_IDX_W-1:0]   set_idx_type;
   typedef logic [WAY_IDX_W-1:0]   way_idx_type;
   typedef logic [CFG_SET_W-1:0]   set_cfg_type;
   typedef logic [CFG_BLOCK_W-1:0] block_cfg_type;
   typedef logic [CFG_WAYS_W-1:0]  ways_cfg_type;
   typedef logic [SPLIT_W-1:0]     split_type;

   // access kinds
   typedef enum logic [OP_W-1:0] {
      OP_INSTR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_STORE  = 2'd2,
      OP_MODIFY = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_BLOCK_BITS = 2'd1,
      CSR_WAYS       = 2'd2
   } csr_idx_type;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // one row of the line store: a whole set
   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][WORD_W-1:0] tag;
      logic [MAX_WAYS-1:0][WORD_W-1:0] last_use;
   } row_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic lookup;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

// File: rtl/slc_if.sv
// ---------------------------------------------------------------------------
// slc_if
// Valid/ready channels for trace accesses and for per-access results.
// ---------------------------------------------------------------------------
interface slc_req_if;
   logic                          valid;
   logic                          ready;
   logic [slc_pkg::OP_W-1:0]      op;
   logic [slc_pkg::WORD_W-1:0]    address;

   modport source (output valid, output op, output address, input ready);
   modport sink   (input valid, input op, input address, output ready);
endinterface

interface slc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          was_hit;
   logic                          was_miss;
   logic                          was_eviction;
   logic                          second_hit;
   logic [slc_pkg::WORD_W-1:0]    hit_total;
   logic [slc_pkg::WORD_W-1:0]    miss_total;
   logic [slc_pkg::WORD_W-1:0]    eviction_total;

   modport source (output valid, output was_hit, output was_miss, output was_eviction,
                   output second_hit, output hit_total, output miss_total,
                   output eviction_total, input ready);
   modport sink   (input valid, input was_hit, input was_miss, input was_eviction,
                   input second_hit, input hit_total, input miss_total,
                   input eviction_total, output ready);
endinterface

// File: rtl/slc_ctrl.sv
// ---------------------------------------------------------------------------
// slc_ctrl
// Controller: clearing sweep after reset, then accept / lookup sequencing.
// ---------------------------------------------------------------------------
module slc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output slc_pkg::cmd_type    cmd,
   input  slc_pkg::status_type status
);

   slc_pkg::state_type state_ff;
   slc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slc_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = slc_pkg::ST_IDLE;
         end
         slc_pkg::ST_IDLE: begin
            if (req_valid) state_in = slc_pkg::ST_LOOKUP;
         end
         slc_pkg::ST_LOOKUP: begin
            if (status.out_free) state_in = slc_pkg::ST_IDLE;
         end
         default: state_in = slc_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.clear_wr = 1'b0;
      cmd.lookup   = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         slc_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         slc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.lookup = req_valid;
         end
         slc_pkg::ST_LOOKUP: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/slc_datapath.sv
// ---------------------------------------------------------------------------
// slc_datapath
// Configuration, address split, set store, tag compare, LRU pick, write-back,
// running totals and the result register.
// ---------------------------------------------------------------------------
module slc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [slc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [slc_pkg::OP_W-1:0]        req_op,
   input  logic [slc_pkg::WORD_W-1:0]      req_address,
   input  slc_pkg::cmd_type                cmd,
   output slc_pkg::status_type             status,
   slc_rsp_if.source                       rsp
);

   // configuration registers
   slc_pkg::set_cfg_type   set_bits_ff;
   slc_pkg::block_cfg_type block_bits_ff;
   slc_pkg::ways_cfg_type  ways_ff;

   // address split
   slc_pkg::set_cfg_type   sb_eff;
   slc_pkg::word_type      shifted;
   slc_pkg::word_type      set_mask;
   slc_pkg::set_idx_type   set_sel;
   slc_pkg::split_type     split;
   slc_pkg::word_type      tag_sel;

   // latched transaction
   slc_pkg::op_type        op_ff;
   slc_pkg::set_idx_type   set_ff;
   slc_pkg::word_type      tag_ff;
   slc_pkg::row_type       rd_row_ff;

   // line store
   slc_pkg::row_type       mem [slc_pkg::NUM_SETS];
   logic                   mem_we;
   slc_pkg::set_idx_type   mem_waddr;
   slc_pkg::row_type       mem_wdata;
   slc_pkg::set_idx_type   clear_idx_ff;

   // lookup
   logic [slc_pkg::MAX_WAYS-1:0] in_use;
   logic [slc_pkg::MAX_WAYS-1:0] hit_vec;
   logic [slc_pkg::MAX_WAYS-1:0] inv_vec;
   logic                         hit_any;
   logic                         inv_any;
   slc_pkg::way_idx_type         hit_way;
   slc_pkg::way_idx_type         inv_way;
   slc_pkg::way_idx_type         victim;
   slc_pkg::row_type             wr_row;

   // lru tree
   slc_pkg::word_type            node_age [slc_pkg::WAY_IDX_W+1][slc_pkg::TREE_LEAVES];
   slc_pkg::way_idx_type         node_way [slc_pkg::WAY_IDX_W+1][slc_pkg::TREE_LEAVES];
   logic                         node_ok  [slc_pkg::WAY_IDX_W+1][slc_pkg::TREE_LEAVES];
   slc_pkg::way_idx_type         lru_way;

   // totals and time
   slc_pkg::word_type      time_ff;
   slc_pkg::word_type      hit_ff;
   slc_pkg::word_type      miss_ff;
   slc_pkg::word_type      evict_ff;
   slc_pkg::word_type      hit_in;
   slc_pkg::word_type      miss_in;
   slc_pkg::word_type      evict_in;
   logic                   is_access;
   logic                   is_modify;
   logic                   now_hit;
   logic                   now_miss;
   logic                   now_evict;

   // result register
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_miss_ff;
   logic                   rsp_evict_ff;
   logic                   rsp_second_ff;
   slc_pkg::word_type      rsp_hit_total_ff;
   slc_pkg::word_type      rsp_miss_total_ff;
   slc_pkg::word_type      rsp_evict_total_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= slc_pkg::set_cfg_type'(slc_pkg::SET_BITS_RST);
         block_bits_ff <= slc_pkg::block_cfg_type'(slc_pkg::BLOCK_BITS_RST);
         ways_ff       <= slc_pkg::ways_cfg_type'(slc_pkg::WAYS_RST);
      end else if (csr_we) begin
         unique case (csr_index)
            slc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_wdata[slc_pkg::CFG_SET_W-1:0];
            slc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[slc_pkg::CFG_BLOCK_W-1:0];
            slc_pkg::CSR_WAYS:       ways_ff       <= csr_wdata[slc_pkg::CFG_WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   // split the incoming address into set and tag
   always_comb begin
      sb_eff   = (set_bits_ff > slc_pkg::set_cfg_type'(slc_pkg::MAX_SET_BITS))
                 ? slc_pkg::set_cfg_type'(slc_pkg::MAX_SET_BITS) : set_bits_ff;
      shifted  = req_address >> block_bits_ff;
      set_mask = (slc_pkg::word_type'(1) << sb_eff) - slc_pkg::word_type'(1);
      set_sel  = slc_pkg::set_idx_type'(shifted & set_mask);
      split    = slc_pkg::split_type'(sb_eff) + slc_pkg::split_type'(block_bits_ff);
      // a split of the whole word leaves no tag bits
      tag_sel  = (split >= slc_pkg::split_type'(slc_pkg::WORD_W))
                 ? '0 : (req_address >> split);
   end

   // latch the transaction at accept
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         op_ff  <= slc_pkg::op_type'(req_op);
         set_ff <= set_sel;
         tag_ff <= tag_sel;
      end
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_idx_ff <= clear_idx_ff + slc_pkg::set_idx_type'(1);
      end
   end

   assign status.clear_last =
      (clear_idx_ff == slc_pkg::set_idx_type'(slc_pkg::NUM_SETS - 1));

   // write port: sweep rows or the looked-up set
   assign is_access = (op_ff != slc_pkg::OP_INSTR);
   assign is_modify = (op_ff == slc_pkg::OP_MODIFY);
   assign mem_we    = cmd.clear_wr | (cmd.commit & is_access);
   assign mem_waddr = cmd.clear_wr ? clear_idx_ff : set_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : wr_row;

   // set store, one row per set, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.lookup) begin
         rd_row_ff <= mem[set_sel];
      end
   end

   // way compare and first free way
   always_comb begin
      hit_way = '0;
      inv_way = '0;
      for (int w = 0; w < slc_pkg::MAX_WAYS; w++) begin
         in_use[w]  = (ways_ff == '0) ? (w == 0)
                      : (ways_ff > slc_pkg::ways_cfg_type'(w));
         hit_vec[w] = in_use[w] & rd_row_ff.valid[w] & (rd_row_ff.tag[w] == tag_ff);
         inv_vec[w] = in_use[w] & ~rd_row_ff.valid[w];
      end
      for (int w = slc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = slc_pkg::way_idx_type'(w);
         if (inv_vec[w]) inv_way = slc_pkg::way_idx_type'(w);
      end
      hit_any = |hit_vec;
      inv_any = |inv_vec;
   end

   // oldest in-use way, ties to the lower way
   always_comb begin
      for (int l = 0; l <= slc_pkg::WAY_IDX_W; l++) begin
         for (int i = 0; i < slc_pkg::TREE_LEAVES; i++) begin
            node_age[l][i] = '0;
            node_way[l][i] = '0;
            node_ok[l][i]  = 1'b0;
         end
      end
      for (int i = 0; i < slc_pkg::TREE_LEAVES; i++) begin
         if (i < slc_pkg::MAX_WAYS) begin
            node_age[0][i] = time_ff - rd_row_ff.last_use[i];
            node_way[0][i] = slc_pkg::way_idx_type'(i);
            node_ok[0][i]  = in_use[i];
         end
      end
      for (int l = 1; l <= slc_pkg::WAY_IDX_W; l++) begin
         for (int i = 0; i < slc_pkg::TREE_LEAVES / 2; i++) begin
            if (i < (slc_pkg::TREE_LEAVES >> l)) begin
               if (node_ok[l-1][2*i+1] &&
                   (!node_ok[l-1][2*i] || node_age[l-1][2*i+1] > node_age[l-1][2*i])) begin
                  node_age[l][i] = node_age[l-1][2*i+1];
                  node_way[l][i] = node_way[l-1][2*i+1];
               end else begin
                  node_age[l][i] = node_age[l-1][2*i];
                  node_way[l][i] = node_way[l-1][2*i];
               end
               node_ok[l][i] = node_ok[l-1][2*i] | node_ok[l-1][2*i+1];
            end
         end
      end
      lru_way = node_way[slc_pkg::WAY_IDX_W][0];
   end

   // line to refresh or fill, and the row to write back
   always_comb begin
      victim = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
      wr_row = rd_row_ff;
      wr_row.valid[victim]    = 1'b1;
      wr_row.tag[victim]      = tag_ff;
      wr_row.last_use[victim] = time_ff;
   end

   // next totals
   always_comb begin
      now_hit   = is_access & hit_any;
      now_miss  = is_access & ~hit_any;
      now_evict = now_miss & ~inv_any;
      hit_in    = hit_ff + slc_pkg::word_type'(now_hit) + slc_pkg::word_type'(is_modify);
      miss_in   = miss_ff + slc_pkg::word_type'(now_miss);
      evict_in  = evict_ff + slc_pkg::word_type'(now_evict);
   end

   // time and running counts
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         hit_ff   <= '0;
         miss_ff  <= '0;
         evict_ff <= '0;
      end else if (cmd.commit) begin
         time_ff  <= time_ff + slc_pkg::word_type'(1);
         hit_ff   <= hit_in;
         miss_ff  <= miss_in;
         evict_ff <= evict_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff         <= now_hit;
         rsp_miss_ff        <= now_miss;
         rsp_evict_ff       <= now_evict;
         rsp_second_ff      <= is_modify;
         rsp_hit_total_ff   <= hit_in;
         rsp_miss_total_ff  <= miss_in;
         rsp_evict_total_ff <= evict_in;
      end
   end

   assign status.out_free = ~rsp_valid_ff | rsp.ready;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.was_hit        = rsp_hit_ff;
   assign rsp.was_miss       = rsp_miss_ff;
   assign rsp.was_eviction   = rsp_evict_ff;
   assign rsp.second_hit     = rsp_second_ff;
   assign rsp.hit_total      = rsp_hit_total_ff;
   assign rsp.miss_total     = rsp_miss_total_ff;
   assign rsp.eviction_total = rsp_evict_total_ff;

endmodule

// File: rtl/set_assoc_lru_cache_sim_top.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top
// Set-associative cache simulator with LRU replacement and running totals.
//
//   channel  direction  handshake             payload
//   req_bus  in         valid/ready           op, address
//   rsp_bus  out        valid/ready           hit/miss/eviction flags, totals
//   csr_*    in         write enable only     register index, write data
//
// In the accept cycle the set's row is read from the line store into a
// register; in the lookup state the tags are compared, the LRU way is picked
// and the row is written back while the result register is loaded.
// After reset a clearing pass writes all 256 rows (one row per cycle) before
// the first request is taken; configuration writes are taken throughout.
// A result waiting in the output register does not block the next accept;
// only a second result behind a stalled one holds the lookup cycle.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top (
   input  logic                            clock,
   input  logic                            reset,
   slc_req_if.sink                         req_bus,
   slc_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [slc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   slc_pkg::cmd_type    cmd;
   slc_pkg::status_type status;

   // sequencing
   slc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // storage and arithmetic
   slc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_op      (req_bus.op),
      .req_address (req_bus.address),
      .cmd         (cmd),
      .status      (status),
      .rsp         (rsp_bus)
   );

`ifndef SYNTH
   // one transaction in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a lookup was pending");

   // a commit always presents a result
   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_bus.valid)
      else $error("commit did not load the result register");

   // a new result only follows a commit
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.commit))
      else $error("result appeared without a commit");

   // hit and miss are exclusive
   a_hit_miss_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.was_hit && rsp_bus.was_miss))
      else $error("result flagged as both hit and miss");
`endif

endmodule

// File: tb/cache_result_checker.sv
// ---------------------------------------------------------------------------
// cache_result_checker
// Follows the trace accesses taken by the cache, works out each access's
// outcome (hit, miss, eviction, second hit, running totals) from its own
// copy of the line store and geometry, and compares every result field by
// field against the oldest predicted outcome.
// ---------------------------------------------------------------------------
module cache_result_checker
   import slc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   slc_req_if                    req_mon,
   slc_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int LINE_COUNT = NUM_SETS * MAX_WAYS;

   typedef struct packed {
      logic     was_hit;
      logic     was_miss;
      logic     was_eviction;
      logic     second_hit;
      word_type hit_total;
      word_type miss_total;
      word_type eviction_total;
   } trace_outcome_type;

   // predicted line store and counters
   logic     line_ok    [LINE_COUNT];
   word_type line_tag   [LINE_COUNT];
   word_type line_stamp [LINE_COUNT];
   word_type time_now;
   word_type hits;
   word_type misses;
   word_type evictions;

   // geometry as last written
   set_cfg_type   geo_set_bits;
   block_cfg_type geo_block_bits;
   ways_cfg_type  geo_ways;

   trace_outcome_type expected_outcomes [$];
   int                errors;

   // one access of the item: lookup, then refresh, fill or evict
   function automatic void touch_line(input word_type addr, output logic hit,
                                      output logic miss, output logic evict);
      int          sb;
      int          bb;
      int          ways;
      int          base;
      int          slot;
      int          victim;
      int          w;
      logic        done;
      logic [63:0] wide;
      word_type    tag;
      word_type    age;
      word_type    oldest;
      sb    = (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(geo_set_bits);
      bb    = int'(geo_block_bits);
      ways  = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : int'(geo_ways));
      wide  = {32'd0, addr} >> bb;
      base  = int'(wide & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
      wide  = {32'd0, addr} >> (sb + bb);
      tag   = (sb + bb >= WORD_W) ? '0 : wide[WORD_W-1:0];
      hit   = 1'b0;
      miss  = 1'b0;
      evict = 1'b0;
      done  = 1'b0;
      // tag match among the ways in use
      for (w = 0; w < ways; w++) begin
         slot = base + w;
         if (!done && line_ok[slot] && line_tag[slot] == tag) begin
            line_stamp[slot] = time_now;
            hit  = 1'b1;
            done = 1'b1;
         end
      end
      if (!done) begin
         miss = 1'b1;
         // first free way takes the line
         for (w = 0; w < ways; w++) begin
            slot = base + w;
            if (!done && !line_ok[slot]) begin
               line_ok[slot]    = 1'b1;
               line_tag[slot]   = tag;
               line_stamp[slot] = time_now;
               done = 1'b1;
            end
         end
      end
      if (!done) begin
         // all ways busy: oldest way goes, lowest way wins a tie
         victim = 0;
         oldest = time_now - line_stamp[base];
         for (w = 1; w < ways; w++) begin
            age = time_now - line_stamp[base + w];
            if (age > oldest) begin
               oldest = age;
               victim = w;
            end
         end
         line_tag[base + victim]   = tag;
         line_stamp[base + victim] = time_now;
         evict = 1'b1;
      end
   endfunction

   function automatic trace_outcome_type predict_trace(input op_type op, input word_type addr);
      trace_outcome_type res;
      logic              hit;
      logic              miss;
      logic              evict;
      res = '0;
      if (op != OP_INSTR) begin
         touch_line(addr, hit, miss, evict);
         res.was_hit      = hit;
         res.was_miss     = miss;
         res.was_eviction = evict;
         if (hit)   hits++;
         if (miss)  misses++;
         if (evict) evictions++;
         // modify: the store half always hits
         if (op == OP_MODIFY) begin
            res.second_hit = 1'b1;
            hits++;
         end
      end
      time_now++;
      res.hit_total      = hits;
      res.miss_total     = misses;
      res.eviction_total = evictions;
      return res;
   endfunction

   function automatic void compare_field(input string name, input word_type want,
                                         input word_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      trace_outcome_type want;
      if (reset) begin
         for (int i = 0; i < LINE_COUNT; i++) line_ok[i] = 1'b0;
         time_now       = '0;
         hits           = '0;
         misses         = '0;
         evictions      = '0;
         geo_set_bits   = set_cfg_type'(SET_BITS_RST);
         geo_block_bits = block_cfg_type'(BLOCK_BITS_RST);
         geo_ways       = ways_cfg_type'(WAYS_RST);
         expected_outcomes.delete();
         errors = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_SET_BITS:   geo_set_bits   = csr_wdata[CFG_SET_W-1:0];
               CSR_BLOCK_BITS: geo_block_bits = csr_wdata[CFG_BLOCK_W-1:0];
               CSR_WAYS:       geo_ways       = csr_wdata[CFG_WAYS_W-1:0];
               default: ;
            endcase
         end
         // result transaction against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result transaction with no access outstanding");
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               compare_field("was_hit", word_type'(want.was_hit),
                             word_type'(rsp_mon.was_hit));
               compare_field("was_miss", word_type'(want.was_miss),
                             word_type'(rsp_mon.was_miss));
               compare_field("was_eviction", word_type'(want.was_eviction),
                             word_type'(rsp_mon.was_eviction));
               compare_field("second_hit", word_type'(want.second_hit),
                             word_type'(rsp_mon.second_hit));
               compare_field("hit_total", want.hit_total, rsp_mon.hit_total);
               compare_field("miss_total", want.miss_total, rsp_mon.miss_total);
               compare_field("eviction_total", want.eviction_total,
                             rsp_mon.eviction_total);
            end
         end
         // access transaction
         if (req_mon.valid && req_mon.ready)
            expected_outcomes.push_back(predict_trace(op_type'(req_mon.op), req_mon.address));
      end
      fail_count    <= errors;
      pending_count <= expected_outcomes.size();
   end

endmodule

// File: tb/set_assoc_lru_cache_sim_top_tb.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top_tb
// Drives trace accesses into the cache under random geometries with random
// gaps and response back-pressure; the result checker predicts and compares.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top_tb;
   import slc_pkg::*;

   localparam int ACCESS_TARGET  = 1000;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 4;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    idle_cycles = 0;
   logic                  req_calm = 1'b0;
   logic                  rsp_calm = 1'b0;

   slc_req_if req_bus ();
   slc_rsp_if rsp_bus ();

   set_assoc_lru_cache_sim_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cache_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one access transaction, after a random gap
   task automatic send_access(input op_type op, input word_type addr);
      int gap;
      if ($urandom_range(0, 31) == 0) req_calm = ~req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.address <= addr;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the three geometry registers back to back
   task automatic program_cache(input logic [CSR_DATA_W-1:0] sb,
                                input logic [CSR_DATA_W-1:0] bb,
                                input logic [CSR_DATA_W-1:0] ways);
      csr_we    <= 1'b1;
      csr_index <= CSR_SET_BITS;
      csr_wdata <= sb;
      @(posedge clock);
      csr_index <= CSR_BLOCK_BITS;
      csr_wdata <= bb;
      @(posedge clock);
      csr_index <= CSR_WAYS;
      csr_wdata <= ways;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // response side: random stalls with calm stretches
   initial begin : rsp_side
      int stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_calm = ~rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin : stimulus
      word_type addr_pool [12];
      word_type addr;
      int       sent;
      int       phase_len;
      int       sb;
      int       bb;
      int       ways;
      int       split;
      int       i;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.op      <= OP_INSTR;
      req_bus.address <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_SET_BITS;
      csr_wdata       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: direct mapped, 16 sets of 16-byte lines
      send_access(OP_INSTR, 32'hFFFF_FFFF);
      send_access(OP_LOAD, 32'h0000_0000);
      send_access(OP_LOAD, 32'h0000_000F);
      send_access(OP_STORE, 32'h0000_0100);
      send_access(OP_MODIFY, 32'h0000_0000);
      send_access(OP_MODIFY, 32'hFFFF_FFFF);
      send_access(OP_STORE, 32'hFFFF_FFF0);
      drain_results();

      // zero set bits, byte lines, eight ways: fill, refresh, then LRU victims
      program_cache(5'd0, 5'd0, 5'd8);
      for (i = 1; i <= 8; i++) send_access(OP_LOAD, word_type'(i));
      send_access(OP_LOAD, 32'd1);
      send_access(OP_STORE, 32'd9);
      send_access(OP_LOAD, 32'd2);
      drain_results();

      // oversized set bits and ways, split beyond the word: tag is zero
      program_cache(5'd15, 5'd31, 5'd15);
      send_access(OP_LOAD, 32'hFFFF_FFFF);
      send_access(OP_LOAD, 32'h0000_0000);
      send_access(OP_MODIFY, 32'h8000_0000);
      drain_results();

      // split exactly at the word edge, zero ways taken as one
      program_cache(5'd8, 5'd24, 5'd0);
      send_access(OP_LOAD, 32'hABCD_1234);
      send_access(OP_STORE, 32'h12CD_0000);
      drain_results();

      // random phases, each under its own geometry and address pool
      sent = 0;
      while (sent < ACCESS_TARGET) begin
         sb   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
         bb   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
         ways = $urandom_range(0, 15);
         split = ((sb > MAX_SET_BITS) ? MAX_SET_BITS : sb) + bb;
         program_cache(CSR_DATA_W'(sb + 16 * $urandom_range(0, 1)), CSR_DATA_W'(bb),
                       CSR_DATA_W'(ways + 16 * $urandom_range(0, 1)));
         for (i = 0; i < 12; i++) addr_pool[i] = $urandom;
         phase_len = $urandom_range(40, 150);
         for (i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               addr = $urandom;
            end else begin
               addr = addr_pool[$urandom_range(0, 11)];
               // same set, other tag: provokes evictions
               if (split < WORD_W && $urandom_range(0, 1) == 1)
                  addr = addr ^ (word_type'($urandom_range(0, 7)) << split);
               addr = addr ^ ($urandom & 32'h0000_000F);
            end
            send_access(op_type'($urandom_range(0, 3)), addr);
         end
         sent += phase_len;
         drain_results();
      end

      // verdict
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
